### rtl/ile_pkg.sv
package ile_pkg;

	// action codes
	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_SEARCH = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_MISS  = 2'd3;

	// request word
	typedef struct packed {
		logic [1:0]         action;
		logic [6:0]         position;
		logic signed [31:0] value;
	} req_t;

	// response word
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] count;
		logic [6:0] found_index;
	} rsp_t;

	// per-cycle command broadcast along the cell row
	typedef struct packed {
		logic ins;   // open a slot at target, shift upper entries up
		logic rem;   // drop entry at target, shift upper entries down
		logic srch;  // latch compare result in every cell
	} ctl_t;

endpackage

### rtl/ile_cell.sv
module ile_cell #(
	parameter int IDX = 0,
	parameter int PW  = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ile_pkg::ctl_t      ctl,
	input  logic [PW-1:0]      target,
	input  logic [PW-1:0]      count,
	input  logic signed [31:0] value,
	input  logic signed [31:0] left,
	input  logic signed [31:0] right,
	output logic signed [31:0] data,
	output logic               hit
);

	localparam logic [PW-1:0] MY_IDX = PW'(IDX);

	logic signed [31:0] data_q;
	logic               hit_q;

	// entry storage: load, take from lower neighbour or from upper neighbour
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (MY_IDX == target) begin
				data_q <= value;
			end else if (MY_IDX > target) begin
				data_q <= left;
			end
		end else if (ctl.rem && (MY_IDX >= target)) begin
			data_q <= right;
		end
	end

	// search match, only for occupied slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.srch) begin
			hit_q <= (MY_IDX < count) && (data_q == value);
		end
	end

	assign data = data_q;
	assign hit  = hit_q;

endmodule

### rtl/ile_search_tree.sv
module ile_search_tree #(
	parameter int N_LEAF = 128
) (
	input  logic                          clk,
	input  logic [N_LEAF-1:0]             hits,
	output logic                          found,
	output logic [$clog2(N_LEAF)-1:0]     index
);

	localparam int LVL = $clog2(N_LEAF);
	localparam int NP  = 1 << LVL;
	localparam int IW  = LVL;

	logic [NP-1:0]   leaf_hit;
	logic [NP-1:1]   hit_q;
	logic [IW-1:0]   idx_q [1:NP-1];
	logic [2*NP-1:2] nh;
	logic [IW-1:0]   ni [2:2*NP-1];

	// unused leaves beyond the capacity never match
	assign leaf_hit = NP'(hits);

	// node view: registered inner nodes, leaves straight from the cells
	always_comb begin
		for (int k = 2; k < NP; k++) begin
			nh[k] = hit_q[k];
			ni[k] = idx_q[k];
		end
		for (int i = 0; i < NP; i++) begin
			nh[NP+i] = leaf_hit[i];
			ni[NP+i] = IW'(i);
		end
	end

	// one registered level per tree level, lower index wins
	always_ff @(posedge clk) begin
		for (int k = 1; k < NP; k++) begin
			hit_q[k] <= nh[2*k] | nh[2*k+1];
			idx_q[k] <= nh[2*k] ? ni[2*k] : ni[2*k+1];
		end
	end

	assign found = hit_q[1];
	assign index = idx_q[1];

endmodule

### rtl/indexed_list_engine.sv
// Append, insert and remove: one word per cycle while the response register can drain, result
// registered in the cycle after acceptance. Search: the cell row latches its matches, then a
// registered priority tree of log2(CAPACITY) levels picks the lowest index; the result is registered
// once the tree has settled and the response register is free, and the next word is taken after it.
// A request is taken whenever no search is resolving and the response register is free or draining.
// Reset clears the entry count and the handshake state; entry contents are not cleared.
module indexed_list_engine #(
	parameter int CAPACITY = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ile_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ile_pkg::rsp_t rsp
);

	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int PW  = (CW > 7) ? CW : 7;
	localparam int LVL = $clog2(CAPACITY);
	localparam int WW  = $clog2(LVL + 1);
	localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

	logic [CW-1:0]       count_q;
	logic                busy_q;
	logic [WW-1:0]       wait_q;
	logic                rsp_valid_q;
	ile_pkg::rsp_t       rsp_q;

	logic                acc;
	logic                out_free;
	logic [PW-1:0]       cnt_p;
	logic [PW-1:0]       pos_p;
	logic [PW-1:0]       target;
	ile_pkg::ctl_t       ctl;
	logic [1:0]          st_now;
	logic [CW-1:0]       cnt_nx;
	logic                srch_done;

	logic signed [31:0]  cell_data [CAPACITY];
	logic [CAPACITY-1:0] cell_hit;
	logic                tree_found;
	logic [LVL-1:0]      tree_index;

	// handshake
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = busy_q || !out_free;
	assign acc       = req_valid && !req_stall;
	assign srch_done = busy_q && (wait_q == '0) && out_free;

	assign cnt_p = PW'(count_q);
	assign pos_p = PW'(req.position);

	// decode the request into a row command and an immediate status
	always_comb begin
		ctl    = '0;
		st_now = ile_pkg::ST_OK;
		cnt_nx = count_q;
		target = pos_p;
		unique case (req.action)
			ile_pkg::ACT_APPEND: begin
				target = cnt_p;
				if (cnt_p == CAP_P) begin
					st_now = ile_pkg::ST_FULL;
				end else begin
					ctl.ins = acc;
					cnt_nx  = count_q + 1'b1;
				end
			end
			ile_pkg::ACT_INSERT: begin
				if (cnt_p == CAP_P) begin
					st_now = ile_pkg::ST_FULL;
				end else if (pos_p > cnt_p) begin
					st_now = ile_pkg::ST_RANGE;
				end else begin
					ctl.ins = acc;
					cnt_nx  = count_q + 1'b1;
				end
			end
			ile_pkg::ACT_REMOVE: begin
				if (pos_p >= cnt_p) begin
					st_now = ile_pkg::ST_RANGE;
				end else begin
					ctl.rem = acc;
					cnt_nx  = count_q - 1'b1;
				end
			end
			ile_pkg::ACT_SEARCH: begin
				ctl.srch = acc;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	// row of cells, each linked to both neighbours
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_w;
		logic signed [31:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = cell_data[i];
		end else begin : g_inner_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_inner_r
			assign right_w = cell_data[i+1];
		end
		ile_cell #(
			.IDX (i),
			.PW  (PW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.target (target),
			.count  (cnt_p),
			.value  (req.value),
			.left   (left_w),
			.right  (right_w),
			.data   (cell_data[i]),
			.hit    (cell_hit[i])
		);
	end

	// lowest matching index
	ile_search_tree #(
		.N_LEAF (CAPACITY)
	) u_tree (
		.clk    (clk),
		.hits   (cell_hit),
		.found  (tree_found),
		.index  (tree_index)
	);

	// count and search sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			wait_q  <= '0;
		end else begin
			if (acc) begin
				count_q <= cnt_nx;
			end
			if (ctl.srch) begin
				busy_q <= 1'b1;
				wait_q <= WW'(LVL);
			end else if (busy_q && (wait_q != '0)) begin
				wait_q <= wait_q - 1'b1;
			end else if (srch_done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((acc && !ctl.srch) || srch_done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (srch_done) begin
			rsp_q.count <= 8'(count_q);
			if (tree_found) begin
				rsp_q.status      <= ile_pkg::ST_OK;
				rsp_q.found_index <= 7'(tree_index);
			end else begin
				rsp_q.status      <= ile_pkg::ST_MISS;
				rsp_q.found_index <= '0;
			end
		end else if (acc && !ctl.srch) begin
			rsp_q.status      <= st_now;
			rsp_q.count       <= 8'(cnt_nx);
			rsp_q.found_index <= '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ile_pkg::*;

	localparam int LIST_CAP    = 128;
	localparam int IDLE_PCT    = 32;
	localparam int HOLD_LEN    = 120;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 30;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// shadow copy of the list contents
	logic [31:0] shadow_vals [LIST_CAP];
	int          shadow_len;
	rsp_t        pending_rsp [$];
	int          fail_cnt;
	int          quiet_cycles;
	bit          calm;
	bit          hold_req;
	bit          grow;

	indexed_list_engine #(
		.CAPACITY(LIST_CAP)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// apply one request to the shadow list and return the response it should give
	function automatic rsp_t list_apply(req_t w);
		rsp_t r;
		int   i;
		r = '0;
		case (w.action)
			ACT_APPEND: begin
				if (shadow_len >= LIST_CAP) begin
					r.status = ST_FULL;
				end else begin
					shadow_vals[shadow_len] = w.value;
					shadow_len++;
					r.status = ST_OK;
				end
			end
			ACT_INSERT: begin
				// full is reported ahead of a bad index
				if (shadow_len >= LIST_CAP) begin
					r.status = ST_FULL;
				end else if (int'(w.position) > shadow_len) begin
					r.status = ST_RANGE;
				end else begin
					for (i = shadow_len; i > int'(w.position); i--)
						shadow_vals[i] = shadow_vals[i - 1];
					shadow_vals[w.position] = w.value;
					shadow_len++;
					r.status = ST_OK;
				end
			end
			ACT_REMOVE: begin
				if (int'(w.position) >= shadow_len) begin
					r.status = ST_RANGE;
				end else begin
					for (i = int'(w.position); i + 1 < shadow_len; i++)
						shadow_vals[i] = shadow_vals[i + 1];
					shadow_len--;
					r.status = ST_OK;
				end
			end
			default: begin
				// scan downwards so the lowest hit is the one kept
				r.status = ST_MISS;
				for (i = shadow_len - 1; i >= 0; i--) begin
					if (shadow_vals[i] == w.value) begin
						r.status      = ST_OK;
						r.found_index = i[6:0];
					end
				end
			end
		endcase
		r.count = shadow_len[7:0];
		return r;
	endfunction

	// offer one word, hold it until taken, then log its expected response
	task automatic send_word(logic [1:0] act, int pos, logic [31:0] val);
		req_t w;
		w.action   = act;
		w.position = pos[6:0];
		w.value    = val;
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_rsp.push_back(list_apply(w));
	endtask

	// mostly legal requests with content that hits often; the mix drifts the
	// list between empty and full
	task automatic send_random_word();
		logic [1:0]  act;
		logic [31:0] val;
		int          pos;
		int          pick;
		if (shadow_len == 0)
			grow = 1'b1;
		else if (shadow_len == LIST_CAP && $urandom_range(0, 3) == 0)
			grow = 1'b0;
		else if ($urandom_range(0, 99) == 0)
			grow = !grow;
		pick = $urandom_range(0, 99);
		if (grow)
			act = pick < 30 ? ACT_APPEND : pick < 65 ? ACT_INSERT :
				pick < 75 ? ACT_REMOVE : ACT_SEARCH;
		else
			act = pick < 10 ? ACT_APPEND : pick < 20 ? ACT_INSERT :
				pick < 75 ? ACT_REMOVE : ACT_SEARCH;
		if ($urandom_range(0, 9) == 0)
			pos = $urandom_range(0, 127);
		else if (act == ACT_REMOVE && shadow_len > 0)
			pos = $urandom_range(0, shadow_len - 1);
		else
			pos = $urandom_range(0, shadow_len < LIST_CAP ? shadow_len : LIST_CAP - 1);
		pick = $urandom_range(0, 9);
		if (pick < 3)
			val = $urandom_range(0, 7) - 4;
		else if (pick < 6 && shadow_len > 0)
			val = shadow_vals[$urandom_range(0, shadow_len - 1)];
		else
			val = $urandom;
		send_word(act, pos, val);
	endtask

	// empty list, value extremes, duplicates and every index error
	task automatic test_edges();
		send_word(ACT_REMOVE, 0, 32'd0);
		send_word(ACT_SEARCH, 0, 32'd0);
		send_word(ACT_INSERT, 1, 32'd5);
		send_word(ACT_INSERT, 0, 32'h8000_0000);
		send_word(ACT_APPEND, 127, 32'h7FFF_FFFF);
		send_word(ACT_INSERT, 2, 32'hFFFF_FFFF);
		send_word(ACT_INSERT, 1, 32'd0);
		send_word(ACT_SEARCH, 0, 32'hFFFF_FFFF);
		send_word(ACT_APPEND, 0, 32'd0);
		send_word(ACT_SEARCH, 0, 32'd0);
		send_word(ACT_SEARCH, 127, 32'd12345);
		send_word(ACT_REMOVE, 127, 32'd0);
		send_word(ACT_REMOVE, 5, 32'd0);
		send_word(ACT_INSERT, 6, 32'd9);
		send_word(ACT_INSERT, 127, 32'd9);
		send_word(ACT_REMOVE, 0, 32'd0);
		send_word(ACT_REMOVE, 3, 32'd0);
		send_word(ACT_SEARCH, 0, 32'h8000_0000);
		send_word(ACT_SEARCH, 0, 32'h7FFF_FFFF);
		while (shadow_len > 0)
			send_word(ACT_REMOVE, 0, 32'd0);
	endtask

	// fill to capacity, poke the full list, then empty it again
	task automatic test_fill_drain();
		while (shadow_len < LIST_CAP) begin
			if ($urandom_range(0, 1))
				send_word(ACT_APPEND, $urandom_range(0, 127), $urandom);
			else
				send_word(ACT_INSERT, $urandom_range(0, shadow_len), $urandom);
		end
		send_word(ACT_APPEND, 0, 32'd1);
		send_word(ACT_INSERT, 127, 32'd2);
		send_word(ACT_INSERT, 0, 32'd3);
		send_word(ACT_SEARCH, 0, shadow_vals[LIST_CAP - 1]);
		send_word(ACT_REMOVE, 127, 32'd0);
		send_word(ACT_INSERT, 127, 32'h5A5A_A5A5);
		send_word(ACT_SEARCH, 0, 32'h5A5A_A5A5);
		while (shadow_len > 0)
			send_word(ACT_REMOVE, $urandom_range(0, shadow_len - 1), $urandom);
	endtask

	// receiver holds off for a long stretch while words keep coming
	task automatic test_output_holdoff();
		hold_req = 1'b1;
		repeat (40)
			send_random_word();
	endtask

	// long random run with a stretch free of idling on both sides
	task automatic test_random_mix(int n_words);
		for (int k = 0; k < n_words; k++) begin
			calm = (k >= n_words / 3) && (k < n_words / 3 + 250);
			send_random_word();
		end
		calm = 1'b0;
	endtask

	// receiver: random stalls, or a counted hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// response checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("response word with nothing pending");
				fail_cnt++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					fail_cnt++;
				end
				if (rsp.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, rsp.count);
					fail_cnt++;
				end
				if (rsp.found_index !== want.found_index) begin
					$error("found_index: expected %0d, got %0d",
						want.found_index, rsp.found_index);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		fail_cnt     = 0;
		quiet_cycles = 0;
		calm         = 1'b0;
		hold_req     = 1'b0;
		grow         = 1'b1;
		shadow_len   = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_edges();
		test_fill_drain();
		test_output_holdoff();
		test_random_mix(1350);

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
